@@ hdl/lpmr_pkg.sv @@
`timescale 1ns / 1ps

package lpmr_pkg;

   // Ring geometry
   localparam int RING_WORDS = 64;
   localparam int PTR_W      = (RING_WORDS > 1) ? $clog2(RING_WORDS) : 1;
   localparam int FREE_W     = $clog2(RING_WORDS + 1);

   // Field widths
   localparam int KIND_W    = 2;
   localparam int MLEN_W    = 16;
   localparam int WORD_W    = 32;
   localparam int OLEN_W    = 8;
   localparam int PAD_W     = 15;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // Longest message a pop reports, in bytes
   localparam logic [OLEN_W-1:0] MAX_POP_LEN = OLEN_W'(252);

   // Request kinds carried in req_tuser
   localparam logic [KIND_W-1:0] REQ_PUSH_HDR  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_PUSH_DATA = 2'd1;
   localparam logic [KIND_W-1:0] REQ_POP       = 2'd2;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_TOO_BIG  = 3'd1,
      STATUS_OVERFLOW = 3'd2,
      STATUS_EMPTY    = 3'd3,
      STATUS_BUSY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_HDR,
      S_POP_WORD,
      S_POP_ZERO
   } state_type;

   // Ring memory access for one cycle
   typedef struct packed {
      logic              wr_en;
      logic [PTR_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [PTR_W-1:0]  rd_addr;
   } mem_req_type;

   // Advance a ring pointer with wrap
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(RING_WORDS - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

endpackage

@@ hdl/lpmr_ram.sv @@
`timescale 1ns / 1ps

module lpmr_ram (
   input  logic                          clock,
   input  lpmr_pkg::mem_req_type         mem_req,
   output logic [lpmr_pkg::WORD_W-1:0]   rd_data
);

   logic [lpmr_pkg::WORD_W-1:0] ring_mem [lpmr_pkg::RING_WORDS];
   logic [lpmr_pkg::WORD_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ring_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= ring_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lpmr_ctrl.sv @@
`timescale 1ns / 1ps

module lpmr_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lpmr_pkg::KIND_W-1:0]     req_kind,
   input  logic [lpmr_pkg::MLEN_W-1:0]     req_length,
   input  logic [lpmr_pkg::WORD_W-1:0]     req_word,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output lpmr_pkg::status_type            rsp_status,
   output logic [lpmr_pkg::OLEN_W-1:0]     rsp_length,
   output logic [lpmr_pkg::WORD_W-1:0]     rsp_word,
   output logic                            rsp_last,
   output lpmr_pkg::mem_req_type           mem_req,
   input  logic [lpmr_pkg::WORD_W-1:0]     mem_rd_data
);

   lpmr_pkg::state_type state_ff, state_in;

   logic [lpmr_pkg::PTR_W-1:0]  wp_ff, wp_in;
   logic [lpmr_pkg::PTR_W-1:0]  rp_ff, rp_in;
   logic                        full_ff, full_in;
   logic [lpmr_pkg::PAD_W-1:0]  words_left_ff, words_left_in;
   logic                        discarding_ff, discarding_in;
   logic [lpmr_pkg::OLEN_W-1:0] len_ff, len_in;
   logic [lpmr_pkg::OLEN_W-1:0] bytes_left_ff, bytes_left_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   lpmr_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [lpmr_pkg::OLEN_W-1:0] rsp_length_ff, rsp_length_in;
   logic [lpmr_pkg::WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_load;

   logic                        skid_valid_ff, skid_valid_in;
   lpmr_pkg::status_type        skid_status_ff, skid_status_in;
   logic [lpmr_pkg::OLEN_W-1:0] skid_length_ff, skid_length_in;
   logic [lpmr_pkg::WORD_W-1:0] skid_word_ff, skid_word_in;
   logic                        skid_last_ff, skid_last_in;

   lpmr_pkg::status_type        item_status;
   logic [lpmr_pkg::OLEN_W-1:0] item_length;
   logic [lpmr_pkg::WORD_W-1:0] item_word;
   logic                        item_last;

   logic                        slot_free;
   logic                        accept;
   logic                        busy;
   logic                        empty;
   logic                        pop_go;
   logic [lpmr_pkg::FREE_W-1:0] free_words;
   logic [lpmr_pkg::PAD_W-1:0]  padded;
   logic [lpmr_pkg::OLEN_W-1:0] hdr_len;
   logic                        last_word;
   logic [lpmr_pkg::WORD_W-1:0] masked_word;

   // Decode shared by both state machine blocks
   always_comb begin
      slot_free = !skid_valid_ff;
      accept    = req_tvalid && slot_free && (state_ff == lpmr_pkg::S_IDLE);
      busy      = (words_left_ff != '0);
      empty     = !full_ff && (rp_ff == wp_ff);
      pop_go    = accept && (req_kind == lpmr_pkg::REQ_POP) && !busy && !empty;
      padded    = lpmr_pkg::PAD_W'(({1'b0, req_length} + 17'd3) >> 2);
      if (full_ff) begin
         free_words = '0;
      end else if (wp_ff >= rp_ff) begin
         free_words = lpmr_pkg::FREE_W'(lpmr_pkg::RING_WORDS)
                      - lpmr_pkg::FREE_W'(wp_ff) + lpmr_pkg::FREE_W'(rp_ff);
      end else begin
         free_words = lpmr_pkg::FREE_W'(rp_ff) - lpmr_pkg::FREE_W'(wp_ff);
      end
      if (mem_rd_data[lpmr_pkg::MLEN_W-1:0] > lpmr_pkg::MLEN_W'(lpmr_pkg::MAX_POP_LEN)) begin
         hdr_len = lpmr_pkg::MAX_POP_LEN;
      end else begin
         hdr_len = mem_rd_data[lpmr_pkg::OLEN_W-1:0];
      end
      last_word = (bytes_left_ff <= lpmr_pkg::OLEN_W'(4));
      // Zero the bytes past the message end
      masked_word = mem_rd_data;
      if (bytes_left_ff < lpmr_pkg::OLEN_W'(4)) begin
         case (bytes_left_ff[1:0])
            2'd1:    masked_word = mem_rd_data & 32'h0000_00FF;
            2'd2:    masked_word = mem_rd_data & 32'h0000_FFFF;
            2'd3:    masked_word = mem_rd_data & 32'h00FF_FFFF;
            default: masked_word = '0;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpmr_pkg::S_IDLE: begin
            if (pop_go) begin
               state_in = lpmr_pkg::S_POP_HDR;
            end
         end
         lpmr_pkg::S_POP_HDR: begin
            if (hdr_len == '0) begin
               state_in = lpmr_pkg::S_POP_ZERO;
            end else begin
               state_in = lpmr_pkg::S_POP_WORD;
            end
         end
         lpmr_pkg::S_POP_WORD: begin
            if (slot_free && last_word) begin
               state_in = lpmr_pkg::S_IDLE;
            end
         end
         lpmr_pkg::S_POP_ZERO: begin
            if (slot_free) begin
               state_in = lpmr_pkg::S_IDLE;
            end
         end
         default: state_in = lpmr_pkg::S_IDLE;
      endcase
   end

   // Outputs, memory access and datapath updates
   always_comb begin
      req_tready    = slot_free && (state_ff == lpmr_pkg::S_IDLE);
      mem_req       = '0;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      full_in       = full_ff;
      words_left_in = words_left_ff;
      discarding_in = discarding_ff;
      len_in        = len_ff;
      bytes_left_in = bytes_left_ff;
      rsp_load      = 1'b0;
      item_status   = lpmr_pkg::STATUS_OK;
      item_length   = '0;
      item_word     = '0;
      item_last     = 1'b0;
      case (state_ff)
         lpmr_pkg::S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  lpmr_pkg::REQ_PUSH_HDR: begin
                     rsp_load    = 1'b1;
                     item_length = '0;
                     item_word   = '0;
                     item_last   = 1'b1;
                     if (busy) begin
                        item_status = lpmr_pkg::STATUS_BUSY;
                     end else begin
                        words_left_in = padded;
                        if (padded >= lpmr_pkg::PAD_W'(lpmr_pkg::RING_WORDS)) begin
                           item_status   = lpmr_pkg::STATUS_TOO_BIG;
                           discarding_in = (padded != '0);
                        end else if (padded >= lpmr_pkg::PAD_W'(free_words)) begin
                           item_status   = lpmr_pkg::STATUS_OVERFLOW;
                           discarding_in = (padded != '0);
                        end else begin
                           item_status     = lpmr_pkg::STATUS_OK;
                           discarding_in   = 1'b0;
                           mem_req.wr_en   = 1'b1;
                           mem_req.wr_addr = wp_ff;
                           mem_req.wr_data = lpmr_pkg::WORD_W'(req_length);
                           wp_in           = lpmr_pkg::next_ptr(wp_ff);
                           full_in         = (lpmr_pkg::next_ptr(wp_ff) == rp_ff);
                        end
                     end
                  end
                  lpmr_pkg::REQ_PUSH_DATA: begin
                     if (busy) begin
                        words_left_in = words_left_ff - lpmr_pkg::PAD_W'(1);
                        if (!discarding_ff) begin
                           mem_req.wr_en   = 1'b1;
                           mem_req.wr_addr = wp_ff;
                           mem_req.wr_data = req_word;
                           wp_in           = lpmr_pkg::next_ptr(wp_ff);
                           full_in         = (lpmr_pkg::next_ptr(wp_ff) == rp_ff);
                        end
                        if (words_left_ff == lpmr_pkg::PAD_W'(1)) begin
                           discarding_in = 1'b0;
                        end
                     end
                  end
                  lpmr_pkg::REQ_POP: begin
                     if (busy || empty) begin
                        rsp_load    = 1'b1;
                        item_status = busy ? lpmr_pkg::STATUS_BUSY : lpmr_pkg::STATUS_EMPTY;
                        item_length = '0;
                        item_word   = '0;
                        item_last   = 1'b1;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = rp_ff;
                        rp_in           = lpmr_pkg::next_ptr(rp_ff);
                        full_in         = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         lpmr_pkg::S_POP_HDR: begin
            // Header word arrived: latch length, fetch first data word if there is one
            len_in        = hdr_len;
            bytes_left_in = hdr_len;
            if (hdr_len != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rp_ff;
               rp_in           = lpmr_pkg::next_ptr(rp_ff);
            end
         end
         lpmr_pkg::S_POP_WORD: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               item_status = lpmr_pkg::STATUS_OK;
               item_length = len_ff;
               item_word   = masked_word;
               item_last   = last_word;
               if (!last_word) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = rp_ff;
                  rp_in           = lpmr_pkg::next_ptr(rp_ff);
                  bytes_left_in   = bytes_left_ff - lpmr_pkg::OLEN_W'(4);
               end
            end
         end
         lpmr_pkg::S_POP_ZERO: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               item_status = lpmr_pkg::STATUS_OK;
               item_length = len_ff;
               item_word   = '0;
               item_last   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Load a new item into the output register, or into the spare slot while it waits; else advance the spare item
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_last_in    = rsp_last_ff;
      skid_valid_in  = skid_valid_ff;
      skid_status_in = skid_status_ff;
      skid_length_in = skid_length_ff;
      skid_word_in   = skid_word_ff;
      skid_last_in   = skid_last_ff;
      if (rsp_load) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = item_status;
            rsp_length_in = item_length;
            rsp_word_in   = item_word;
            rsp_last_in   = item_last;
         end else begin
            skid_valid_in  = 1'b1;
            skid_status_in = item_status;
            skid_length_in = item_length;
            skid_word_in   = item_word;
            skid_last_in   = item_last;
         end
      end else if (rsp_tready) begin
         if (skid_valid_ff) begin
            // Advance the spare item into the output register
            rsp_status_in = skid_status_ff;
            rsp_length_in = skid_length_ff;
            rsp_word_in   = skid_word_ff;
            rsp_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lpmr_pkg::S_IDLE;
         wp_ff         <= '0;
         rp_ff         <= '0;
         full_ff       <= 1'b0;
         words_left_ff <= '0;
         discarding_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         full_ff       <= full_in;
         words_left_ff <= words_left_in;
         discarding_ff <= discarding_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      len_ff         <= len_in;
      bytes_left_ff  <= bytes_left_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_last_ff    <= rsp_last_in;
      skid_status_ff <= skid_status_in;
      skid_length_ff <= skid_length_in;
      skid_word_ff   <= skid_word_in;
      skid_last_ff   <= skid_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_last   = rsp_last_ff;

   // Full ring only with both pointers together
   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (wp_ff == rp_ff))
      else $error("ring full with pointers apart");

   // Dropping data only while words are still expected
   a_discard_words: assert property (@(posedge clock) disable iff (reset)
      discarding_ff |-> (words_left_ff != '0))
      else $error("discarding with no words left");

   // No ring writes while a pop streams out
   a_no_write_in_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lpmr_pkg::S_IDLE) |-> !mem_req.wr_en)
      else $error("ring write during pop");

   // A word state always has bytes still to send
   a_word_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpmr_pkg::S_POP_WORD) |-> (bytes_left_ff != '0))
      else $error("pop word state with no bytes left");

   // The spare slot fills only behind a waiting output item
   a_skid_behind: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("spare item without output item");

endmodule

@@ hdl/length_prefixed_message_ring.sv @@
`timescale 1ns / 1ps

// Message ring: a queue of variable-length messages kept in a 64-word memory.
// req channel: req_tuser selects push header (with byte length), push data
// word, or pop. A push header answers one rsp item with a status (ok, too
// big, overflow, busy); its data words follow as further req items and give
// no rsp item. After a too-big or overflow header the announced words are dropped.
// A pop answers with one rsp item per data word of the oldest message,
// bytes past its length zeroed, tlast on the final one; a zero-length
// message gives one item; an empty ring or an unfinished push give one
// status item. Each rsp item carries tlast = 1 on the end of its answer.
// Timing: a pop reads the header word from the memory, then streams one word
// per cycle while the spare rsp slot is free, through the single read port of
// the ring memory. No new req item is taken until a pop is done.
// Reset clears pointers, full flag and push tracking; the ring is empty.
// A stalled rsp channel holds its item; a spare slot behind the output
// register takes one more rsp item, so a stall drops req_tready only once both
// are full, and req_tready never follows rsp_tready within the same cycle.

module length_prefixed_message_ring (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] msg_length, [47:16] data_word
   input  logic [lpmr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] req_type
   input  logic [lpmr_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] out_length, [39:8] out_word
   output logic [lpmr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [2:0] status
   output logic [2:0]                        rsp_tuser,
   output logic                              rsp_tlast
);

   lpmr_pkg::mem_req_type       mem_req;
   logic [lpmr_pkg::WORD_W-1:0] mem_rd_data;
   lpmr_pkg::status_type        rsp_status;
   logic [lpmr_pkg::OLEN_W-1:0] rsp_length;
   logic [lpmr_pkg::WORD_W-1:0] rsp_word;

   lpmr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_tuser),
      .req_length  (req_tdata[15:0]),
      .req_word    (req_tdata[47:16]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_length  (rsp_length),
      .rsp_word    (rsp_word),
      .rsp_last    (rsp_tlast),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   lpmr_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // Pack the result item
   assign rsp_tdata = {rsp_word, rsp_length};
   assign rsp_tuser = rsp_status;

endmodule

@@ bench/length_prefixed_message_ring_tb.sv @@
`timescale 1ns / 1ps

import lpmr_pkg::*;

// One rsp item as the ring should produce it
typedef struct {
   status_type        status;
   logic [OLEN_W-1:0] out_length;
   logic [WORD_W-1:0] out_word;
   logic              is_final;
} ring_reply_type;

// Mirror of the message ring: tracks contents and pointers, queues the replies due
class message_ring_mirror;
   logic [WORD_W-1:0] ring_words [RING_WORDS];
   logic [PTR_W-1:0]  wr_ptr;
   logic [PTR_W-1:0]  rd_ptr;
   logic              full;
   logic [PAD_W-1:0]  words_due;
   logic              dropping;
   ring_reply_type    replies_due [$];
   int                mismatch_count;

   function new();
      foreach (ring_words[i]) ring_words[i] = '0;
      wr_ptr         = '0;
      rd_ptr         = '0;
      full           = 1'b0;
      words_due      = '0;
      dropping       = 1'b0;
      mismatch_count = 0;
   endfunction

   function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
      return (32'(p) == RING_WORDS - 1) ? '0 : p + 1'b1;
   endfunction

   function int unsigned free_words();
      if (full) return 0;
      if (wr_ptr >= rd_ptr) return RING_WORDS - 32'(wr_ptr) + 32'(rd_ptr);
      return 32'(rd_ptr) - 32'(wr_ptr);
   endfunction

   function void add_reply(status_type st, logic [OLEN_W-1:0] olen,
                           logic [WORD_W-1:0] w, logic fin);
      ring_reply_type r;
      r.status     = st;
      r.out_length = olen;
      r.out_word   = w;
      r.is_final   = fin;
      replies_due.push_back(r);
   endfunction

   // Store one word at the write pointer and advance it
   function void store_word(logic [WORD_W-1:0] w);
      ring_words[wr_ptr] = w;
      wr_ptr = step_ptr(wr_ptr);
      if (wr_ptr == rd_ptr) full = 1'b1;
   endfunction

   // Apply one accepted req item and queue the replies it causes
   function void take_request(logic [KIND_W-1:0] kind, logic [MLEN_W-1:0] len,
                              logic [WORD_W-1:0] word);
      int unsigned padded;
      int unsigned mlen;
      int unsigned nwords;
      int unsigned rem;
      logic [WORD_W-1:0] w;
      status_type st;
      padded = (32'(len) + 3) >> 2;
      case (kind)
         REQ_PUSH_HDR: begin
            if (words_due != 0) begin
               add_reply(STATUS_BUSY, '0, '0, 1'b1);
               return;
            end
            st = STATUS_OK;
            if (padded + 1 > RING_WORDS) st = STATUS_TOO_BIG;
            else if (padded + 1 > free_words()) st = STATUS_OVERFLOW;
            words_due = PAD_W'(padded);
            if (st != STATUS_OK) begin
               dropping = (words_due != 0);
            end else begin
               dropping = 1'b0;
               store_word({16'b0, len});
            end
            add_reply(st, '0, '0, 1'b1);
         end
         REQ_PUSH_DATA: begin
            if (words_due == 0) return;
            words_due = words_due - 1'b1;
            if (!dropping) store_word(word);
            if (words_due == 0) dropping = 1'b0;
         end
         REQ_POP: begin
            if (words_due != 0) begin
               add_reply(STATUS_BUSY, '0, '0, 1'b1);
               return;
            end
            if (!full && rd_ptr == wr_ptr) begin
               add_reply(STATUS_EMPTY, '0, '0, 1'b1);
               return;
            end
            mlen = 32'(ring_words[rd_ptr][15:0]);
            if (mlen > 252) mlen = 252;
            rd_ptr = step_ptr(rd_ptr);
            nwords = (mlen + 3) >> 2;
            full = 1'b0;
            if (nwords == 0) begin
               add_reply(STATUS_OK, OLEN_W'(mlen), '0, 1'b1);
               return;
            end
            for (int unsigned i = 0; i < nwords; i++) begin
               w = ring_words[rd_ptr];
               rem = mlen - 4 * i;
               // zero the bytes past the message end
               if (rem < 4) w = w & ((32'd1 << (8 * rem)) - 1);
               add_reply(STATUS_OK, OLEN_W'(mlen), w, (i + 1 == nwords));
               rd_ptr = step_ptr(rd_ptr);
            end
         end
         default: begin
         end
      endcase
   endfunction

   task note_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Compare one accepted rsp item with the oldest reply due
   task check_reply(logic [2:0] got_status, logic [RSP_DATA_W-1:0] got_data,
                    logic got_last);
      ring_reply_type e;
      if (replies_due.size() == 0) begin
         note_mismatch($sformatf("unexpected item status %0d data %h", got_status, got_data));
         return;
      end
      e = replies_due.pop_front();
      if (got_status !== e.status)
         note_mismatch($sformatf("status %0d, want %0d", got_status, e.status));
      if (got_data[7:0] !== e.out_length)
         note_mismatch($sformatf("length %0d, want %0d", got_data[7:0], e.out_length));
      if (got_data[39:8] !== e.out_word)
         note_mismatch($sformatf("word %h, want %h", got_data[39:8], e.out_word));
      if (got_last !== e.is_final)
         note_mismatch($sformatf("tlast %b, want %b", got_last, e.is_final));
   endtask
endclass

module length_prefixed_message_ring_tb;

   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
   localparam int TIMEOUT_NS = 500_000 * 20;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;

   message_ring_mirror mirror;
   int snd_idle_pct;
   int rcv_idle_pct;
   int hold_left;
   int items_sent;

   length_prefixed_message_ring DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic int padded_words(logic [MLEN_W-1:0] len);
      return (32'(len) + 3) >> 2;
   endfunction

   // Pick a message length, mostly short
   function automatic logic [MLEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(99, 0);
      if (r < 60) return MLEN_W'($urandom_range(12, 0));
      if (r < 90) return MLEN_W'($urandom_range(40, 13));
      if (r < 98) return MLEN_W'($urandom_range(120, 41));
      return MLEN_W'($urandom_range(252, 121));
   endfunction

   // Offer one req item, with random idle cycles ahead of it
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [MLEN_W-1:0] len,
                            input logic [WORD_W-1:0] word);
      @(negedge clock);
      while ($urandom_range(99, 0) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {word, len};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mirror.take_request(kind, len, word);
   endtask

   task automatic send_words(input int n);
      repeat (n) send_item(REQ_PUSH_DATA, MLEN_W'($urandom), $urandom);
   endtask

   task automatic send_pop();
      send_item(REQ_POP, MLEN_W'($urandom), $urandom);
   endtask

   // Header plus exactly the data words it announces
   task automatic send_message(input logic [MLEN_W-1:0] len);
      send_item(REQ_PUSH_HDR, len, $urandom);
      send_words(padded_words(len));
      items_sent += 1 + padded_words(len);
   endtask

   // Hold the sender until every reply due has come back
   task automatic wait_for_replies();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (mirror.replies_due.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= rcv_idle_pct);
         end
      end
   end

   // Check every accepted rsp item
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            mirror.check_reply(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int r;
      int room;
      int span;
      int cut;
      int phase;
      logic [MLEN_W-1:0] len;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      mirror       = new();
      snd_idle_pct = 25;
      rcv_idle_pct = 46;
      hold_left    = 0;
      items_sent   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty ring, stray and unused items, zero-length message
      send_pop();
      send_item(REQ_PUSH_DATA, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(REQ_PUSH_HDR, 16'd0, 32'hFFFF_FFFF);
      send_pop();
      // requests while a push is unfinished are busy; tail bytes masked on pop
      send_item(REQ_PUSH_HDR, 16'd5, '0);
      send_pop();
      send_item(REQ_PUSH_HDR, 16'd9, '0);
      send_item(REQ_PUSH_DATA, '0, 32'hFFFF_FFFF);
      send_item(REQ_PUSH_DATA, '0, 32'hFFFF_FFFF);
      send_item(REQ_PUSH_HDR, 16'd3, '0);
      send_item(REQ_PUSH_DATA, '0, 32'hFFFF_FFFF);
      send_item(REQ_PUSH_HDR, 16'd4, '0);
      send_item(REQ_PUSH_DATA, '0, '0);
      repeat (3) send_pop();
      send_pop();
      wait_for_replies();
      items_sent = 0;

      // Random: mostly well-formed messages and pops, some noise
      phase = 0;
      while (items_sent < 210) begin
         if (phase == 0 && items_sent >= 70) begin
            wait_for_replies();
            phase = 1;
            snd_idle_pct = 46;
            rcv_idle_pct = 25;
         end
         if (phase == 1 && items_sent >= 140) begin
            wait_for_replies();
            phase = 2;
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
            hold_left = 400;
         end
         r = $urandom_range(99, 0);
         if (r < 48) begin
            send_message(pick_length());
         end else if (r < 76) begin
            send_pop();
            items_sent++;
         end else if (r < 82) begin
            // fill the free space exactly when it is small
            room = mirror.free_words();
            if (room >= 1 && room <= 24) begin
               span = room - 1;
               len = (span == 0) ? '0 : MLEN_W'(4 * span - $urandom_range(3, 0));
               send_message(len);
            end else begin
               send_message(pick_length());
            end
         end else if (r < 88) begin
            send_message(MLEN_W'($urandom_range(300, 253)));
         end else if (r < 94) begin
            // broken push: a header or pop cuts in before the words are done
            len = pick_length();
            span = padded_words(len);
            cut = (span == 0) ? 0 : $urandom_range(span - 1, 0);
            send_item(REQ_PUSH_HDR, len, $urandom);
            send_words(cut);
            if ($urandom_range(1, 0) == 0) send_pop();
            else send_item(REQ_PUSH_HDR, pick_length(), $urandom);
            send_words(span - cut);
            items_sent += 2 + span;
         end else if (r < 97) begin
            send_item(REQ_PUSH_DATA, MLEN_W'($urandom), $urandom);
         end else begin
            send_item(REQ_UNUSED, MLEN_W'($urandom), $urandom);
         end
      end

      // Drain, then allow for anything late or extra
      wait_for_replies();
      repeat (64) @(posedge clock);
      if (mirror.replies_due.size() != 0)
         mirror.note_mismatch($sformatf("%0d replies never came", mirror.replies_due.size()));
      if (mirror.mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/lpmr_pkg.sv
hdl/lpmr_ram.sv
hdl/lpmr_ctrl.sv
hdl/length_prefixed_message_ring.sv
bench/length_prefixed_message_ring_tb.sv
